@@ sv/fat_chain_allocator_unit_defines.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef FAT_CHAIN_ALLOCATOR_UNIT_DEFINES_SVH
`define FAT_CHAIN_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk with reset masked.
`define FCA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fca check failed");

// Next-cycle implication, checked on clk with reset masked.
`define FCA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fca check failed");

`endif

@@ sv/fca_pkg.sv @@
// Shared constants, codes and types of the chain allocator.
`timescale 1ns / 1ps
package fca_pkg;
	localparam int NUM_BLOCKS   = 256;
	localparam int ROOT_ENTRIES = 16;
	localparam int FAT_BLOCKS   = 11;
	localparam int FIRST_DATA   = FAT_BLOCKS + 2;
	localparam int BLK_W        = 8;
	localparam int DIR_W        = 4;
	localparam int KEY_W        = 48;
	localparam int CNT_W        = 9;
	localparam int KIND_W       = 3;
	localparam int STAT_W       = 3;

	localparam logic [KIND_W-1:0] K_CREATE = 3'd0;
	localparam logic [KIND_W-1:0] K_REMOVE = 3'd1;
	localparam logic [KIND_W-1:0] K_FIRST  = 3'd2;
	localparam logic [KIND_W-1:0] K_APPEND = 3'd3;
	localparam logic [KIND_W-1:0] K_UNLINK = 3'd4;
	localparam logic [KIND_W-1:0] K_NEXT   = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
	localparam logic [STAT_W-1:0] ST_EXISTS      = 3'd1;
	localparam logic [STAT_W-1:0] ST_DIR_FULL    = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND   = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_EMPTY   = 3'd4;
	localparam logic [STAT_W-1:0] ST_DISK_FULL   = 3'd5;
	localparam logic [STAT_W-1:0] ST_NOT_IN_FILE = 3'd6;

	localparam logic [BLK_W-1:0] FREE_HEAD_RST = BLK_W'(FIRST_DATA);

	typedef logic [BLK_W-1:0] blk_t;

	typedef struct packed {
		logic rd_en;
		blk_t rd_addr;
		logic wr_en;
		blk_t wr_addr;
		blk_t wr_data;
	} fat_req_t;

	function automatic blk_t fat_reset_val(input blk_t addr);
		if (int'(addr) >= FIRST_DATA && int'(addr) + 1 < NUM_BLOCKS)
			return addr + blk_t'(1);
		return '0;
	endfunction
endpackage

@@ sv/fca_fat.sv @@
// Allocation table memory with per-entry valid bits and registered read.
`timescale 1ns / 1ps
module fca_fat (
	input  logic              clk,
	input  logic              arst_n,
	input  fca_pkg::fat_req_t req,
	output fca_pkg::blk_t     rd_data
);
	import fca_pkg::*;

	blk_t                  mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] valid_q;
	blk_t                  rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= valid_q[req.rd_addr] ? mem[req.rd_addr] : fat_reset_val(req.rd_addr);
		end
	end

	assign rd_data = rd_data_q;
endmodule

@@ sv/fat_chain_allocator_unit.sv @@
// Top level of the directory and allocation-table chain allocator.
// One operation at a time: in_ready is high only while the block is idle.
// Every operation first scans the 16 directory slots, one per cycle,
// then does its table work through the table memory, one access at a time:
// it walks a chain block by block (up to 256 blocks), then makes its updates.
// Create, remove and first-block do no table work; append, unlink and next
// walk the file's chain when it has one. The result is held in an output
// register, so one finished result can wait while the block idles.
`timescale 1ns / 1ps
`include "fat_chain_allocator_unit_defines.svh"
module fat_chain_allocator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [fca_pkg::KIND_W-1:0]   kind,
	input  logic [fca_pkg::KEY_W-1:0]    name_key,
	input  logic [fca_pkg::BLK_W-1:0]    block_number,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [fca_pkg::STAT_W-1:0]   status,
	output logic [fca_pkg::BLK_W-1:0]    block_result
);
	import fca_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DISP, S_APP_RD, S_APP_CHK, S_APP_LINK, S_POP_RD, S_POP_CHK,
		S_FIND_RD, S_FIND_CHK, S_NXT_RD, S_NXT_CHK, S_UNL_PUSH, S_FINISH
	} state_t;

	state_t                  state_q;
	logic [KIND_W-1:0]       kind_q;
	logic [KEY_W-1:0]        key_q;
	blk_t                    blk_q;
	logic [ROOT_ENTRIES-1:0] dir_valid_q;
	logic [KEY_W-1:0]        dir_key_q [ROOT_ENTRIES];
	blk_t                    dir_first_q [ROOT_ENTRIES];
	blk_t                    free_head_q;
	logic [DIR_W-1:0]        idx_q;
	logic [DIR_W-1:0]        didx_q;
	logic [DIR_W-1:0]        fidx_q;
	logic                    found_q;
	logic                    free_found_q;
	blk_t                    b_q;
	blk_t                    p_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [STAT_W-1:0]       st_q;
	blk_t                    res_q;
	logic                    out_valid_q;
	logic [STAT_W-1:0]       status_q;
	blk_t                    block_result_q;

	fat_req_t fat_req;
	blk_t     fat_rd;
	logic     cnt_full;

	assign cnt_full = (cnt_q == CNT_W'(NUM_BLOCKS));

	fca_fat u_fat (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (fat_req),
		.rd_data (fat_rd)
	);

	always_comb begin
		fat_req = '0;
		unique case (state_q)
			S_APP_RD: begin
				fat_req.rd_en   = !cnt_full;
				fat_req.rd_addr = b_q;
			end
			S_APP_LINK: begin
				fat_req.wr_en   = 1'b1;
				fat_req.wr_addr = b_q;
				fat_req.wr_data = free_head_q;
			end
			S_POP_RD: begin
				fat_req.rd_en   = 1'b1;
				fat_req.rd_addr = free_head_q;
			end
			S_POP_CHK: begin
				fat_req.wr_en   = 1'b1;
				fat_req.wr_addr = free_head_q;
			end
			S_FIND_RD: begin
				fat_req.rd_en   = !cnt_full && b_q != '0 && b_q != blk_q;
				fat_req.rd_addr = b_q;
			end
			S_NXT_RD: begin
				fat_req.rd_en   = 1'b1;
				fat_req.rd_addr = blk_q;
			end
			S_NXT_CHK: begin
				fat_req.wr_en   = kind_q == K_UNLINK && p_q != '0;
				fat_req.wr_addr = p_q;
				fat_req.wr_data = fat_rd;
			end
			S_UNL_PUSH: begin
				fat_req.wr_en   = 1'b1;
				fat_req.wr_addr = blk_q;
				fat_req.wr_data = free_head_q;
			end
			default: begin
				fat_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			kind_q         <= '0;
			key_q          <= '0;
			blk_q          <= '0;
			dir_valid_q    <= '0;
			for (int i = 0; i < ROOT_ENTRIES; i++) begin
				dir_key_q[i]   <= '0;
				dir_first_q[i] <= '0;
			end
			free_head_q    <= FREE_HEAD_RST;
			idx_q          <= '0;
			didx_q         <= '0;
			fidx_q         <= '0;
			found_q        <= 1'b0;
			free_found_q   <= 1'b0;
			b_q            <= '0;
			p_q            <= '0;
			cnt_q          <= '0;
			st_q           <= ST_OK;
			res_q          <= '0;
			out_valid_q    <= 1'b0;
			status_q       <= ST_OK;
			block_result_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q       <= kind;
						key_q        <= name_key;
						blk_q        <= block_number;
						idx_q        <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						st_q         <= ST_OK;
						res_q        <= '0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (dir_valid_q[idx_q] && dir_key_q[idx_q] == key_q && !found_q) begin
						found_q <= 1'b1;
						didx_q  <= idx_q;
					end
					if (!dir_valid_q[idx_q] && !free_found_q) begin
						free_found_q <= 1'b1;
						fidx_q       <= idx_q;
					end
					idx_q <= idx_q + DIR_W'(1);
					if (idx_q == DIR_W'(ROOT_ENTRIES - 1)) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					b_q     <= dir_first_q[didx_q];
					p_q     <= '0;
					cnt_q   <= '0;
					state_q <= S_FINISH;
					unique case (kind_q)
						K_CREATE: begin
							if (found_q) begin
								st_q <= ST_EXISTS;
							end else if (free_found_q) begin
								dir_valid_q[fidx_q] <= 1'b1;
								dir_key_q[fidx_q]   <= key_q;
								dir_first_q[fidx_q] <= '0;
							end else begin
								st_q <= ST_DIR_FULL;
							end
						end
						K_REMOVE: begin
							if (!found_q) begin
								st_q <= ST_NOT_FOUND;
							end else if (dir_first_q[didx_q] != '0) begin
								st_q <= ST_NOT_EMPTY;
							end else begin
								dir_valid_q[didx_q] <= 1'b0;
							end
						end
						K_FIRST: begin
							if (!found_q) begin
								st_q <= ST_NOT_FOUND;
							end else begin
								res_q <= dir_first_q[didx_q];
							end
						end
						K_APPEND: begin
							if (free_head_q == '0) begin
								st_q <= ST_DISK_FULL;
							end else if (!found_q) begin
								st_q <= ST_NOT_FOUND;
							end else if (dir_first_q[didx_q] == '0) begin
								dir_first_q[didx_q] <= free_head_q;
								state_q             <= S_POP_RD;
							end else begin
								state_q <= S_APP_RD;
							end
						end
						K_UNLINK, K_NEXT: begin
							if (!found_q) begin
								st_q <= ST_NOT_FOUND;
							end else begin
								state_q <= S_FIND_RD;
							end
						end
						default: begin
							st_q <= ST_OK;
						end
					endcase
				end
				S_APP_RD: begin
					state_q <= cnt_full ? S_APP_LINK : S_APP_CHK;
				end
				S_APP_CHK: begin
					if (fat_rd == '0) begin
						state_q <= S_APP_LINK;
					end else begin
						b_q     <= fat_rd;
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_APP_RD;
					end
				end
				S_APP_LINK: begin
					state_q <= S_POP_RD;
				end
				S_POP_RD: begin
					state_q <= S_POP_CHK;
				end
				S_POP_CHK: begin
					res_q       <= free_head_q;
					free_head_q <= fat_rd;
					state_q     <= S_FINISH;
				end
				S_FIND_RD: begin
					if (cnt_full || b_q == '0) begin
						st_q    <= ST_NOT_IN_FILE;
						state_q <= S_FINISH;
					end else if (b_q == blk_q) begin
						state_q <= S_NXT_RD;
					end else begin
						state_q <= S_FIND_CHK;
					end
				end
				S_FIND_CHK: begin
					p_q     <= b_q;
					b_q     <= fat_rd;
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_FIND_RD;
				end
				S_NXT_RD: begin
					state_q <= S_NXT_CHK;
				end
				S_NXT_CHK: begin
					if (kind_q == K_NEXT) begin
						res_q   <= fat_rd;
						state_q <= S_FINISH;
					end else begin
						if (p_q == '0) begin
							dir_first_q[didx_q] <= fat_rd;
						end
						state_q <= S_UNL_PUSH;
					end
				end
				S_UNL_PUSH: begin
					free_head_q <= blk_q;
					state_q     <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q    <= 1'b1;
						status_q       <= st_q;
						block_result_q <= res_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign block_result = block_result_q;

	`FCA_ASSERT_NEXT(a_accept_starts_scan, in_valid && in_ready, state_q == S_SCAN && idx_q == '0)
	`FCA_ASSERT_NOW(a_walk_bounded, 1'b1, cnt_q <= CNT_W'(NUM_BLOCKS))
	`FCA_ASSERT_NOW(a_error_no_block, out_valid_q && status_q != ST_OK, block_result_q == '0)
	`FCA_ASSERT_NOW(a_one_port_access, 1'b1, !(fat_req.rd_en && fat_req.wr_en))
endmodule
